// ===== rtl/display_char_expander_unit_assert.svh =====
// Assertion macros shared by the display character expander RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef DISPLAY_CHAR_EXPANDER_UNIT_ASSERT_SVH
`define DISPLAY_CHAR_EXPANDER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DCE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dce: same-cycle check failed");

// next-cycle implication
`define DCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dce: next-cycle check failed");

`else

`define DCE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DCE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/dce_pkg.sv =====
// Package for the display character expander: payload structs, register
// indexes, character constants and the ASCII control-name table. No dependencies.
package dce_pkg;

    localparam int COLUMN_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TAB_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NULL_SUBST   = 1'b1;

    localparam logic [5:0] TAB_DIST_RESET  = 6'd8;
    localparam logic [7:0] NULL_SUBST_RESET = 8'd0;

    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_CTL_MAX = 8'd31;
    localparam logic [7:0] CHAR_DEL     = 8'd127;
    localparam logic [7:0] CHAR_LT      = 8'h3C;
    localparam logic [7:0] CHAR_GT      = 8'h3E;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [COLUMN_W-1:0] COLUMN_MAX = 16'hFFFF;

    localparam logic [23:0] NAME_NUL = "nul";
    localparam logic [23:0] NAME_DEL = "del";

    typedef struct packed {
        logic [7:0] in_char;
        logic       line_start;
    } dce_in_t;

    typedef struct packed {
        logic [7:0]          out_char;
        logic                is_last;
        logic [COLUMN_W-1:0] column_after;
    } dce_out_t;

    // name text is left-justified; two-letter names leave the low byte zero
    typedef struct packed {
        logic [1:0]  len;
        logic [23:0] text;
    } ctl_name_t;

    function automatic ctl_name_t ctl_name(input logic [4:0] code);
        ctl_name_t nm;
        nm.len = 2'd3;
        unique case (code)
            5'd0:  nm.text = "nul";
            5'd1:  nm.text = "soh";
            5'd2:  nm.text = "stx";
            5'd3:  nm.text = "etx";
            5'd4:  nm.text = "eot";
            5'd5:  nm.text = "enq";
            5'd6:  nm.text = "ack";
            5'd7:  nm.text = "bel";
            5'd8:  begin nm.text = {"bs", 8'h00}; nm.len = 2'd2; end
            5'd9:  begin nm.text = {"ht", 8'h00}; nm.len = 2'd2; end
            5'd10: begin nm.text = {"nl", 8'h00}; nm.len = 2'd2; end
            5'd11: begin nm.text = {"vt", 8'h00}; nm.len = 2'd2; end
            5'd12: begin nm.text = {"np", 8'h00}; nm.len = 2'd2; end
            5'd13: begin nm.text = {"cr", 8'h00}; nm.len = 2'd2; end
            5'd14: begin nm.text = {"so", 8'h00}; nm.len = 2'd2; end
            5'd15: begin nm.text = {"si", 8'h00}; nm.len = 2'd2; end
            5'd16: nm.text = "dle";
            5'd17: nm.text = "dc1";
            5'd18: nm.text = "dc2";
            5'd19: nm.text = "dc3";
            5'd20: nm.text = "dc4";
            5'd21: nm.text = "nak";
            5'd22: nm.text = "syn";
            5'd23: nm.text = "etb";
            5'd24: nm.text = "can";
            5'd25: begin nm.text = {"em", 8'h00}; nm.len = 2'd2; end
            5'd26: nm.text = "sub";
            5'd27: nm.text = "esc";
            5'd28: begin nm.text = {"fs", 8'h00}; nm.len = 2'd2; end
            5'd29: begin nm.text = {"gs", 8'h00}; nm.len = 2'd2; end
            5'd30: begin nm.text = {"rs", 8'h00}; nm.len = 2'd2; end
            5'd31: begin nm.text = {"us", 8'h00}; nm.len = 2'd2; end
            default: nm.text = "nul";
        endcase
        return nm;
    endfunction

endpackage

// ===== rtl/display_char_expander_unit.sv =====
// Display character expander: tab expansion and <name> forms of control codes, DEL and the null substitute.
// Depends on dce_pkg and display_char_expander_unit_assert.svh.
// A byte goes from ST_IDLE to ST_SUM, a tab via ST_DIV (restoring divider for column % td);
// ST_EMIT then gives 1 plain, 4-5 name or td - column % td spaces, 1/cycle while the output
// register is free. A new byte is taken only in ST_IDLE, once the previous one is emitted.
// Reset (aresetn low, synchronous): column to 0, tab_distance 8, null_substitute 0.
`include "display_char_expander_unit_assert.svh"

module display_char_expander_unit
    import dce_pkg::*;
#(
    parameter int MAX_TAB_STOP = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dce_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dce_out_t             m_data
);

    localparam int TD_W  = $clog2(MAX_TAB_STOP + 1);
    localparam int CNT_W = TD_W;
    localparam logic [3:0] BIT_LAST = 4'(COLUMN_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        KIND_SPACE = 2'd0,
        KIND_WORD  = 2'd1,
        KIND_PLAIN = 2'd2
    } kind_t;

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [5:0]           tab_distance_reg, tab_distance_next;
    logic [7:0]           null_subst_reg, null_subst_next;
    logic [COLUMN_W-1:0]  column_reg, column_next;
    logic [7:0]           char_reg, char_next;
    logic [23:0]          name_reg, name_next;
    logic [TD_W-1:0]      td_reg, td_next;
    logic [TD_W-1:0]      rem_reg, rem_next;
    logic [3:0]           bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic                 m_valid_reg, m_valid_next;
    dce_out_t             m_data_reg, m_data_next;

    logic                 s_xfer;
    logic                 out_free;
    logic                 emit_last;
    logic [TD_W-1:0]      td_clamped;
    ctl_name_t            ctl_nm;
    logic [TD_W:0]        rem_shift;
    logic [TD_W-1:0]      rem_step;
    logic [COLUMN_W:0]    col_sum;
    logic [7:0]           emit_char;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_last = (CNT_W'(k_reg + 1'b1) == n_reg);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign ctl_nm    = ctl_name(s_data.in_char[4:0]);

    always_comb begin
        if (int'(tab_distance_reg) > MAX_TAB_STOP) begin
            td_clamped = TD_W'(MAX_TAB_STOP);
        end else if (tab_distance_reg == 6'd0) begin
            td_clamped = TD_W'(1);
        end else begin
            td_clamped = TD_W'(tab_distance_reg);
        end
    end

    // divider step: shift in the next column bit, subtract if it fits
    assign rem_shift = {rem_reg, column_reg[bit_cnt_reg]};
    always_comb begin
        if (rem_shift >= {1'b0, td_reg}) begin
            rem_step = TD_W'(rem_shift - {1'b0, td_reg});
        end else begin
            rem_step = TD_W'(rem_shift);
        end
    end

    assign col_sum = {1'b0, column_reg} + (COLUMN_W + 1)'(n_reg);

    always_comb begin
        emit_char = char_reg;
        unique case (kind_reg)
            KIND_SPACE: emit_char = CHAR_SPACE;
            KIND_PLAIN: emit_char = char_reg;
            KIND_WORD: begin
                if (k_reg == '0) begin
                    emit_char = CHAR_LT;
                end else if (emit_last) begin
                    emit_char = CHAR_GT;
                end else if (k_reg == CNT_W'(1)) begin
                    emit_char = name_reg[23:16];
                end else if (k_reg == CNT_W'(2)) begin
                    emit_char = name_reg[15:8];
                end else begin
                    emit_char = name_reg[7:0];
                end
            end
            default: emit_char = char_reg;
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        tab_distance_next = tab_distance_reg;
        null_subst_next   = null_subst_reg;
        column_next       = column_reg;
        char_next         = char_reg;
        name_next         = name_reg;
        td_next           = td_reg;
        rem_next          = rem_reg;
        bit_cnt_next      = bit_cnt_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_TAB_DISTANCE: tab_distance_next = cfg_wdata[5:0];
                REG_NULL_SUBST:   null_subst_next   = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    column_next = s_data.line_start ? '0 : column_reg;
                    char_next   = s_data.in_char;
                    state_next  = ST_SUM;
                    // tab beats the null substitute when both match
                    priority if (s_data.in_char == CHAR_TAB) begin
                        kind_next    = KIND_SPACE;
                        td_next      = td_clamped;
                        rem_next     = '0;
                        bit_cnt_next = BIT_LAST;
                        state_next   = ST_DIV;
                    end else if (s_data.in_char == null_subst_reg) begin
                        kind_next = KIND_WORD;
                        name_next = NAME_NUL;
                        n_next    = CNT_W'(5);
                    end else if (s_data.in_char <= CHAR_CTL_MAX) begin
                        kind_next = KIND_WORD;
                        name_next = ctl_nm.text;
                        n_next    = CNT_W'(3'(ctl_nm.len) + 3'd2);
                    end else if (s_data.in_char == CHAR_DEL) begin
                        kind_next = KIND_WORD;
                        name_next = NAME_DEL;
                        n_next    = CNT_W'(5);
                    end else begin
                        kind_next = KIND_PLAIN;
                        n_next    = CNT_W'(1);
                    end
                end
            end
            ST_DIV: begin
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg - 4'd1;
                if (bit_cnt_reg == 4'd0) begin
                    n_next     = td_reg - rem_step;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                column_next = col_sum[COLUMN_W] ? COLUMN_MAX : col_sum[COLUMN_W-1:0];
                k_next      = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.out_char     = emit_char;
                    m_data_next.is_last      = emit_last;
                    m_data_next.column_after = column_reg;
                    k_next                   = CNT_W'(k_reg + 1'b1);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tab_distance_reg <= TAB_DIST_RESET;
            null_subst_reg   <= NULL_SUBST_RESET;
            column_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            tab_distance_reg <= tab_distance_next;
            null_subst_reg   <= null_subst_next;
            column_reg       <= column_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        char_reg    <= char_next;
        name_reg    <= name_next;
        td_reg      <= td_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        m_data_reg  <= m_data_next;
    end

    `DCE_ASSERT_NEXT(a_busy_after_xfer, aclk, aresetn, s_valid && s_ready, !s_ready)
    `DCE_ASSERT_IMPL(a_rem_below_td, aclk, aresetn, state_reg == ST_DIV, rem_reg < td_reg)
    `DCE_ASSERT_IMPL(a_emit_in_range, aclk, aresetn, state_reg == ST_EMIT, k_reg < n_reg)
    `DCE_ASSERT_NEXT(a_last_closes_item, aclk, aresetn,
        state_reg == ST_EMIT && out_free && emit_last,
        state_reg == ST_IDLE && m_valid_reg && m_data_reg.is_last)

endmodule
